// ===== design/srr_pkg.sv =====
package srr_pkg;

   localparam int SEQ_W      = 16;
   localparam int CFG_W      = 5;
   localparam int CSR_ADDR_W = 2;
   localparam int DIGIT_W    = 4;

   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEQ_BITS    = 2'd1;

   localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 5'd4;
   localparam logic [CFG_W-1:0] SEQ_BITS_RESET    = 5'd4;

   typedef enum logic [1:0] {
      KIND_DELIVER = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_RESEND  = 2'd2
   } kind_type;

   // Effective window and sequence-space mask, shared by front and back.
   typedef struct packed {
      logic [CFG_W-1:0] n;
      logic [SEQ_W-1:0] mask;
   } cfg_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MOD,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DRAIN_RD,
      B_DRAIN_CHK,
      B_ACK,
      B_RESEND
   } back_state_type;

   // One restoring step of the remainder by the window size.
   function automatic logic [CFG_W-1:0] mod_step(input logic [CFG_W-1:0] rem,
                                                 input logic            bit_in,
                                                 input logic [CFG_W-1:0] n);
      logic [CFG_W:0] r;
      r = {rem, bit_in};
      if (r >= {1'b0, n}) begin
         r = r - {1'b0, n};
      end
      return r[CFG_W-1:0];
   endfunction

endpackage

// ===== design/srr_fifo.sv =====
module srr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/srr_front.sv =====
module srr_front #(
   parameter int SLOT_W       = 4,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  srr_pkg::cfg_type                cfg,
   input  logic                            push,
   output logic                            full,
   input  logic [srr_pkg::SEQ_W-1:0]       seq_number,
   input  logic                            checksum_ok,
   input  logic [PAYLOAD_BITS-1:0]         payload_word,
   output logic                            cmd_push,
   output logic [1+srr_pkg::SEQ_W+SLOT_W+PAYLOAD_BITS-1:0] cmd_data,
   input  logic                            cmd_full
);

   import srr_pkg::*;

   localparam int STEPS = SEQ_W / DIGIT_W;
   localparam int CNT_W = $clog2(STEPS);

   front_state_type          state_ff, state_in;
   logic [SEQ_W-1:0]         seq_ff, seq_in;
   logic [SEQ_W-1:0]         div_ff, div_in;
   logic                     good_ff, good_in;
   logic [PAYLOAD_BITS-1:0]  pay_ff, pay_in;
   logic [CFG_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CFG_W-1:0]         rem_next;

   // Four remainder bits per cycle, most significant first.
   always_comb begin
      logic [CFG_W-1:0] r;
      r = rem_ff;
      for (int i = 0; i < DIGIT_W; i++) begin
         r = mod_step(r, div_ff[SEQ_W-1-i], cfg.n);
      end
      rem_next = r;
   end

   always_comb begin
      state_in = state_ff;
      seq_in   = seq_ff;
      div_in   = div_ff;
      good_in  = good_ff;
      pay_in   = pay_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      cmd_push = 1'b0;
      full     = (state_ff != F_IDLE);
      unique case (state_ff)
         F_IDLE: begin
            if (push) begin
               seq_in   = seq_number;
               div_in   = seq_number;
               good_in  = checksum_ok;
               pay_in   = payload_word;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = F_MOD;
            end
         end
         F_MOD: begin
            rem_in = rem_next;
            div_in = div_ff << DIGIT_W;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!cmd_full) begin
               cmd_push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign cmd_data = {good_ff, seq_ff, SLOT_W'(rem_ff), pay_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff  <= seq_in;
      div_ff  <= div_in;
      good_ff <= good_in;
      pay_ff  <= pay_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== design/srr_back.sv =====
module srr_back #(
   parameter int MAX_WINDOW   = 16,
   parameter int SLOT_W       = 4,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  srr_pkg::cfg_type         cfg,
   input  logic                     cmd_empty,
   input  logic [1+srr_pkg::SEQ_W+SLOT_W+PAYLOAD_BITS-1:0] cmd_data,
   output logic                     cmd_pop,
   input  logic                     out_full,
   output logic                     out_push,
   output logic [2+srr_pkg::SEQ_W+PAYLOAD_BITS:0] out_data
);

   import srr_pkg::*;

   localparam int CMD_W = 1 + SEQ_W + SLOT_W + PAYLOAD_BITS;

   back_state_type           state_ff, state_in;
   logic [SEQ_W-1:0]         base_ff, base_in;
   logic [SLOT_W-1:0]        j_ff, j_in;
   logic [SEQ_W-1:0]         cur_seq_ff, cur_seq_in;
   logic [SLOT_W-1:0]        cur_slot_ff, cur_slot_in;
   logic [MAX_WINDOW-1:0]    slot_valid_ff;
   logic [MAX_WINDOW-1:0]    ack_valid_ff;

   logic [SEQ_W-1:0]         slot_seq_mem [MAX_WINDOW];
   logic [PAYLOAD_BITS-1:0]  slot_pay_mem [MAX_WINDOW];
   logic [SEQ_W-1:0]         ack_mem      [MAX_WINDOW];
   logic [SEQ_W-1:0]         seq_q;
   logic [PAYLOAD_BITS-1:0]  pay_q;
   logic [SEQ_W-1:0]         ack_q;

   logic                     h_good;
   logic [SEQ_W-1:0]         h_seq;
   logic [SLOT_W-1:0]        h_slot;
   logic [PAYLOAD_BITS-1:0]  h_pay;
   logic [SEQ_W-1:0]         b_eff;
   logic [SEQ_W-1:0]         dist_fwd;
   logic [SEQ_W-1:0]         dist_back;
   logic [SEQ_W-1:0]         n_wide;
   logic                     h_live;
   logic                     in_win;
   logic                     in_prev;

   logic                     slot_wr;
   logic                     slot_clr;
   logic                     ack_wr;
   logic                     ack_rd;
   kind_type                 o_kind;
   logic [SEQ_W-1:0]         o_seq;
   logic [PAYLOAD_BITS-1:0]  o_pay;
   logic                     o_last;

   assign h_good = cmd_data[CMD_W-1];
   assign h_seq  = cmd_data[CMD_W-2 -: SEQ_W];
   assign h_slot = cmd_data[PAYLOAD_BITS +: SLOT_W];
   assign h_pay  = cmd_data[PAYLOAD_BITS-1:0];

   // The base is reduced to the current sequence space before every request.
   assign b_eff     = base_ff & cfg.mask;
   assign n_wide    = SEQ_W'(cfg.n);
   assign dist_fwd  = (h_seq - b_eff) & cfg.mask;
   assign dist_back = (b_eff - h_seq) & cfg.mask;
   assign h_live    = h_good && ((h_seq & ~cfg.mask) == '0);
   assign in_win    = dist_fwd < n_wide;
   assign in_prev   = (dist_back != '0) && (dist_back <= n_wide);

   assign out_data = {o_kind, o_seq, o_pay, o_last};

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      j_in        = j_ff;
      cur_seq_in  = cur_seq_ff;
      cur_slot_in = cur_slot_ff;
      cmd_pop     = 1'b0;
      slot_wr     = 1'b0;
      slot_clr    = 1'b0;
      ack_wr      = 1'b0;
      ack_rd      = 1'b0;
      out_push    = 1'b0;
      o_kind      = KIND_DELIVER;
      o_seq       = '0;
      o_pay       = '0;
      o_last      = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop     = 1'b1;
               cur_seq_in  = h_seq;
               cur_slot_in = h_slot;
               base_in     = b_eff;
               priority if (h_live && in_win) begin
                  slot_wr = !slot_valid_ff[h_slot];
                  if (h_seq == b_eff) begin
                     j_in     = h_slot;
                     state_in = B_DRAIN_RD;
                  end else begin
                     state_in = B_ACK;
                  end
               end else if (h_live && in_prev) begin
                  ack_rd   = 1'b1;
                  state_in = B_RESEND;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         B_DRAIN_RD: begin
            state_in = B_DRAIN_CHK;
         end
         B_DRAIN_CHK: begin
            if (slot_valid_ff[j_ff] && (seq_q == base_ff)) begin
               if (!out_full) begin
                  out_push = 1'b1;
                  o_kind   = KIND_DELIVER;
                  o_seq    = base_ff;
                  o_pay    = pay_q;
                  slot_clr = 1'b1;
                  base_in  = (base_ff + 1'b1) & cfg.mask;
                  // When the base wraps to zero the slot restarts at zero as well,
                  // even if the sequence space is not a multiple of the window.
                  j_in     = ((base_ff == cfg.mask) || (SEQ_W'(j_ff) == n_wide - 1'b1))
                             ? '0 : j_ff + 1'b1;
                  state_in = B_DRAIN_RD;
               end
            end else begin
               state_in = B_ACK;
            end
         end
         B_ACK: begin
            if (!out_full) begin
               out_push = 1'b1;
               o_kind   = KIND_ACK;
               o_seq    = cur_seq_ff;
               o_last   = 1'b1;
               ack_wr   = 1'b1;
               state_in = B_IDLE;
            end
         end
         B_RESEND: begin
            if (!out_full) begin
               out_push = 1'b1;
               o_kind   = KIND_RESEND;
               o_seq    = ack_valid_ff[cur_slot_ff] ? ack_q : '0;
               o_last   = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         base_ff       <= '0;
         slot_valid_ff <= '0;
         ack_valid_ff  <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         if (slot_wr) begin
            slot_valid_ff[h_slot] <= 1'b1;
         end
         if (slot_clr) begin
            slot_valid_ff[j_ff] <= 1'b0;
         end
         if (ack_wr) begin
            ack_valid_ff[cur_slot_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      cur_seq_ff  <= cur_seq_in;
      cur_slot_ff <= cur_slot_in;
   end

   always_ff @(posedge clock) begin
      if (slot_wr) begin
         slot_seq_mem[h_slot] <= h_seq;
         slot_pay_mem[h_slot] <= h_pay;
      end
      if (state_ff == B_DRAIN_RD) begin
         seq_q <= slot_seq_mem[j_ff];
         pay_q <= slot_pay_mem[j_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ack_wr) begin
         ack_mem[cur_slot_ff] <= cur_seq_ff;
      end
      if (ack_rd) begin
         ack_q <= ack_mem[h_slot];
      end
   end

endmodule

// ===== design/selective_repeat_receiver.sv =====
// Selective-repeat receiver. Each request is one packet; good packets inside the
// receive window are buffered by slot, a packet at the window base releases the
// in-order run as deliveries followed by a new acknowledgement, and a good packet
// from the previous window resends the stored acknowledgement of its slot. The
// front end takes no new packet until the last one is through: it accepts the
// packet, runs the serial remainder unit (four bits of the 16-bit sequence
// number per cycle against the window size) and hands the packet to a two-entry
// queue, waiting while that queue is full. The back end classifies each packet,
// reads the slot memory and then checks it for each delivered payload, and sends
// an acknowledgement. Results leave through a two-entry queue; a full result
// queue stalls the back end, and the front end once the command queue fills. The
// configuration port is always ready; write it only while no packet is in flight.
module selective_repeat_receiver #(
   parameter int MAX_WINDOW   = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [srr_pkg::SEQ_W-1:0]          req_seq_number,
   input  logic                               req_checksum_ok,
   input  logic [PAYLOAD_BITS-1:0]            req_payload_word,
   output logic                               empty,
   input  logic                               pop,
   output logic [1:0]                         rsp_result_kind,
   output logic [srr_pkg::SEQ_W-1:0]          rsp_out_seq,
   output logic [PAYLOAD_BITS-1:0]            rsp_out_payload,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [srr_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [srr_pkg::CFG_W-1:0]          csr_data
);

   import srr_pkg::*;

   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CMD_W  = 1 + SEQ_W + SLOT_W + PAYLOAD_BITS;
   localparam int OUT_W  = 2 + SEQ_W + PAYLOAD_BITS + 1;

   logic [CFG_W-1:0] window_size_ff, window_size_in;
   logic [CFG_W-1:0] seq_bits_ff, seq_bits_in;
   cfg_type          cfg;
   logic [SEQ_W:0]   modulus;
   logic             seq_bits_fit;

   logic             cmd_push;
   logic             cmd_full;
   logic             cmd_empty;
   logic             cmd_pop;
   logic [CMD_W-1:0] cmd_wr_data;
   logic [CMD_W-1:0] cmd_rd_data;
   logic             out_push;
   logic             out_full;
   logic [OUT_W-1:0] out_wr_data;
   logic [OUT_W-1:0] out_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      window_size_in = window_size_ff;
      seq_bits_in    = seq_bits_ff;
      if (csr_valid) begin
         if (csr_index == CSR_WINDOW_SIZE) begin
            window_size_in = csr_data;
         end else if (csr_index == CSR_SEQ_BITS) begin
            seq_bits_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         seq_bits_ff    <= SEQ_BITS_RESET;
      end else begin
         window_size_ff <= window_size_in;
         seq_bits_ff    <= seq_bits_in;
      end
   end

   // A zero window counts as one; a large one saturates at the slot count.
   // The sequence space falls back to 16 bits unless two windows fit in it.
   always_comb begin
      if (window_size_ff == '0) begin
         cfg.n = CFG_W'(1);
      end else if (32'(window_size_ff) > 32'(MAX_WINDOW)) begin
         cfg.n = CFG_W'(MAX_WINDOW);
      end else begin
         cfg.n = window_size_ff;
      end
      modulus      = (SEQ_W + 1)'(1) << seq_bits_ff;
      seq_bits_fit = (seq_bits_ff != '0) && (seq_bits_ff <= CFG_W'(SEQ_W))
                     && (modulus >= (SEQ_W + 1)'({cfg.n, 1'b0}));
      cfg.mask     = seq_bits_fit ? SEQ_W'(modulus - 1'b1) : '1;
   end

   srr_front #(
      .SLOT_W       (SLOT_W),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .push         (push),
      .full         (full),
      .seq_number   (req_seq_number),
      .checksum_ok  (req_checksum_ok),
      .payload_word (req_payload_word),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_wr_data),
      .cmd_full     (cmd_full)
   );

   srr_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr_data),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty)
   );

   srr_back #(
      .MAX_WINDOW   (MAX_WINDOW),
      .SLOT_W       (SLOT_W),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rd_data),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wr_data)
   );

   srr_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (2)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_wr_data),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_rd_data),
      .empty   (empty)
   );

   assign rsp_result_kind = out_rd_data[OUT_W-1 -: 2];
   assign rsp_out_seq     = out_rd_data[OUT_W-3 -: SEQ_W];
   assign rsp_out_payload = out_rd_data[PAYLOAD_BITS:1];
   assign rsp_last        = out_rd_data[0];

endmodule

// ===== tb/sv/selective_repeat_receiver_tb.sv =====
module selective_repeat_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srr_pkg::*;

   localparam int SLOTS         = 16;
   localparam int WORD_W        = 32;
   localparam int SETTLE_CYCLES = 60;
   localparam int STALL_LIMIT   = 3000;
   localparam int PHASE_ITEMS   = 24;

   typedef struct {
      kind_type          kind;
      logic [SEQ_W-1:0]  seq;
      logic [WORD_W-1:0] word;
      logic              last;
   } arq_result_type;

   // Tracks the receive window and holds the results each request is due to cause.
   class receive_window_board_type;
      arq_result_type    due_results[$];
      int                errors;
      logic [CFG_W-1:0]  win_reg;
      logic [CFG_W-1:0]  seq_reg;
      int unsigned       base;
      bit                held [SLOTS];
      logic [SEQ_W-1:0]  held_seq [SLOTS];
      logic [WORD_W-1:0] held_word [SLOTS];
      logic [SEQ_W-1:0]  acked [SLOTS];

      function new();
         errors  = 0;
         win_reg = WINDOW_SIZE_RESET;
         seq_reg = SEQ_BITS_RESET;
         base    = 0;
         for (int i = 0; i < SLOTS; i++) begin
            held[i]      = 1'b0;
            held_seq[i]  = '0;
            held_word[i] = '0;
            acked[i]     = '0;
         end
      endfunction

      function int unsigned eff_window();
         if (win_reg == 0) return 1;
         if (win_reg > SLOTS) return SLOTS;
         return 32'(win_reg);
      endfunction

      // Two whole windows must fit in the sequence space, otherwise the full 16 bits are used.
      function int unsigned eff_modulus();
         int unsigned n;
         n = eff_window();
         if (seq_reg >= 1 && seq_reg <= 16 && (32'd1 << seq_reg) >= 2 * n) return 32'd1 << seq_reg;
         return 32'd65536;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] index, logic [CFG_W-1:0] value);
         if (index == CSR_WINDOW_SIZE) win_reg = value;
         else if (index == CSR_SEQ_BITS) seq_reg = value;
      endfunction

      function void queue_result(kind_type kind, logic [SEQ_W-1:0] seq,
                                 logic [WORD_W-1:0] word, logic last);
         arq_result_type r;
         r.kind = kind;
         r.seq  = seq;
         r.word = word;
         r.last = last;
         due_results.push_back(r);
      endfunction

      function void take_packet(logic [SEQ_W-1:0] seq, logic ok, logic [WORD_W-1:0] word);
         int unsigned n, m, s, slot, run, back;
         n    = eff_window();
         m    = eff_modulus();
         base = base % m;
         s    = 32'(seq);
         if (!ok || s >= m) return;
         slot = s % n;
         back = (base + m - s) % m;
         if ((s + m - base) % m < n) begin
            if (!held[slot]) begin
               held[slot]      = 1'b1;
               held_seq[slot]  = seq;
               held_word[slot] = word;
            end
            if (s == base) begin
               run = 0;
               while (run < n && held[base % n] && held_seq[base % n] == base) begin
                  queue_result(KIND_DELIVER, SEQ_W'(base), held_word[base % n], 1'b0);
                  held[base % n] = 1'b0;
                  base = (base + 1) % m;
                  run++;
               end
            end
            acked[slot] = seq;
            queue_result(KIND_ACK, seq, '0, 1'b1);
         end else if (back >= 1 && back <= n) begin
            queue_result(KIND_RESEND, acked[slot], '0, 1'b1);
         end
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void check_result(logic [1:0] kind, logic [SEQ_W-1:0] seq,
                                 logic [WORD_W-1:0] word, logic last);
         arq_result_type want;
         if (due_results.size() == 0) begin
            note_error($sformatf("unexpected result: kind %0d seq %0d payload %h last %0d",
                                 kind, seq, word, last));
            return;
         end
         want = due_results.pop_front();
         if (want.kind !== kind || want.seq !== seq || want.word !== word || want.last !== last)
            note_error($sformatf({"result mismatch: expected kind %0d seq %0d payload %h last %0d,",
                                  " got kind %0d seq %0d payload %h last %0d"},
                                 want.kind, want.seq, want.word, want.last,
                                 kind, seq, word, last));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [SEQ_W-1:0]      req_seq_number = '0;
   logic                  req_checksum_ok = 1'b0;
   logic [WORD_W-1:0]     req_payload_word = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [1:0]            rsp_result_kind;
   logic [SEQ_W-1:0]      rsp_out_seq;
   logic [WORD_W-1:0]     rsp_out_payload;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]      csr_data = '0;

   receive_window_board_type board = new();
   bit                       no_idle = 1'b0;

   selective_repeat_receiver u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_seq_number   (req_seq_number),
      .req_checksum_ok  (req_checksum_ok),
      .req_payload_word (req_payload_word),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_out_seq      (rsp_out_seq),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic ok,
                              input logic [WORD_W-1:0] word);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push             <= 1'b1;
      req_seq_number   <= seq;
      req_checksum_ok  <= ok;
      req_payload_word <= word;
      do @(posedge clock); while (full);
      board.take_packet(seq, ok, word);
   endtask

   // Most requests fall in or just behind the window so that drains and resends happen often.
   task automatic send_random_packet();
      int unsigned      n, m, b, pick;
      logic [SEQ_W-1:0] seq;
      logic             ok;
      n    = board.eff_window();
      m    = board.eff_modulus();
      b    = board.base % m;
      pick = $urandom_range(0, 99);
      ok   = 1'b1;
      if (pick < 15) begin
         seq = SEQ_W'(b);
      end else if (pick < 60) begin
         seq = SEQ_W'((b + $urandom_range(0, n - 1)) % m);
      end else if (pick < 75) begin
         seq = SEQ_W'((b + m - $urandom_range(1, n)) % m);
      end else if (pick < 85) begin
         seq = SEQ_W'((b + $urandom_range(0, n - 1)) % m);
         ok  = 1'b0;
      end else if (pick < 93) begin
         seq = SEQ_W'($urandom);
         ok  = 1'($urandom);
      end else begin
         seq = SEQ_W'((b + $urandom_range(n, m - 1)) % m);
      end
      send_packet(seq, ok, $urandom);
   endtask

   // Lets every due result drain and the front end run dry before the registers change.
   task automatic settle();
      @(negedge clock);
      push <= 1'b0;
      while (board.due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] index, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] bits);
      settle();
      write_csr(CSR_WINDOW_SIZE, win);
      write_csr(CSR_SEQ_BITS, bits);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_random_packet();
   endtask

   initial begin : result_sink
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = pick_gap();
         repeat (gap) begin
            @(negedge clock);
            pop <= 1'b0;
         end
         @(negedge clock);
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         board.check_result(rsp_result_kind, rsp_out_seq, rsp_out_payload, rsp_last);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [CFG_W-1:0] wins [12];
      logic [CFG_W-1:0] bits [12];
      wins = '{5'd16, 5'd16, 5'd3, 5'd0, 5'd5, 5'd7, 5'd1, 5'd9, 5'd31, 5'd2, 5'd6, 5'd17};
      bits = '{5'd16, 5'd5, 5'd3, 5'd3, 5'd4, 5'd4, 5'd1, 5'd4, 5'd16, 5'd0, 5'd17, 5'd31};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset window: four numbers out of sixteen, base at zero.
      send_packet(16'd12, 1'b1, 32'h0000_0000);   // ack slot never written
      send_packet(16'd0, 1'b0, 32'hFFFF_FFFF);
      send_packet(16'd16, 1'b1, 32'h1111_1111);
      send_packet(16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      send_packet(16'd2, 1'b1, 32'h0000_0000);
      send_packet(16'd2, 1'b1, 32'h1234_5678);    // duplicate must not overwrite
      send_packet(16'd3, 1'b1, 32'hFFFF_FFFF);
      send_packet(16'd1, 1'b1, 32'hA5A5_A5A5);
      send_packet(16'd0, 1'b1, 32'h5A5A_5A5A);
      send_packet(16'd5, 1'b1, 32'h8000_0001);
      send_packet(16'd4, 1'b1, 32'h7FFF_FFFE);
      send_packet(16'd3, 1'b1, 32'hDEAD_BEEF);
      send_packet(16'd1, 1'b1, 32'h0F0F_0F0F);
      send_packet(16'd10, 1'b1, 32'hF0F0_F0F0);
      send_packet(16'd6, 1'b0, 32'hCAFE_F00D);

      // Smallest window in the smallest sequence space; the old base is folded.
      settle();
      write_csr(CSR_WINDOW_SIZE, 5'd1);
      write_csr(CSR_SEQ_BITS, 5'd1);
      send_packet(16'd1, 1'b1, 32'h0000_0001);
      send_packet(16'd0, 1'b1, 32'hFFFF_0000);
      send_packet(16'd1, 1'b1, 32'h0000_FFFF);
      send_packet(16'd1, 1'b1, 32'h1357_9BDF);
      send_packet(16'd2, 1'b1, 32'h2468_ACE0);

      for (int i = 0; i < 12; i++) run_phase(wins[i], bits[i]);
      repeat (2) run_phase(CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)));

      settle();
      if (board.errors == 0 && board.due_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/srr_pkg.sv
design/srr_fifo.sv
design/srr_front.sv
design/srr_back.sv
design/selective_repeat_receiver.sv
tb/sv/selective_repeat_receiver_tb.sv
